// ----- rtl/core/lattice_gas_swap_step_top_assert.svh -----
// ----------------------------------------------------------------------------
// Lattice gas swap step - assertion macros
// Concurrent assertion helpers; they compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef LATTICE_GAS_SWAP_STEP_TOP_ASSERT_SVH
`define LATTICE_GAS_SWAP_STEP_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every rising clk edge out of reset
`define LGS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define LGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LGS_ASSERT_IMPLY(label, ante, cons, msg)
`define LGS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/core/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants, codes and helpers of the lattice gas swap step block.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

    localparam int GRID_MAX = 64;
    localparam int CELL_W   = $clog2(GRID_MAX);
    localparam int ADDR_W   = 2 * CELL_W;
    localparam int DEPTH    = GRID_MAX * GRID_MAX;

    localparam int COORD_W  = 6;
    localparam int SIDE_W   = 7;
    localparam int SIDE_CAP = (GRID_MAX > 127) ? 127 : GRID_MAX;
    localparam int CNT_W    = 4;
    localparam int DRAW_W   = 16;
    localparam int CFG_W    = 64;

    // scan order: A center, B center, 8 neighbors of A, 8 neighbors of B
    localparam int STEP_W         = 5;
    localparam int STEP_B_CENTER  = 1;
    localparam int STEP_A_NBR     = 2;
    localparam int STEP_B_NBR     = 10;
    localparam int STEP_LAST_SWAP = 17;

    localparam logic [DRAW_W-1:0] THR_HALF = 16'h8000;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_READ = 2'd1,
        REQ_SWAP = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_GRID_SIDE   = 2'd0,
        CFG_ACCEPT_LOW  = 2'd1,
        CFG_ACCEPT_HIGH = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic              wdata;
    } store_req_t;

    localparam logic [SIDE_W-1:0] OFS_NEG = '1;
    localparam logic [SIDE_W-1:0] OFS_ZERO = '0;
    localparam logic [SIDE_W-1:0] OFS_POS = SIDE_W'(1);

    // neighbor j: row above left to right, left, right, row below
    function automatic logic [SIDE_W-1:0] nbr_dx(input logic [2:0] j);
        logic [SIDE_W-1:0] d;
        case (j)
            3'd0, 3'd3, 3'd5: d = OFS_NEG;
            3'd1, 3'd6:       d = OFS_ZERO;
            default:          d = OFS_POS;
        endcase
        return d;
    endfunction

    function automatic logic [SIDE_W-1:0] nbr_dy(input logic [2:0] j);
        logic [SIDE_W-1:0] d;
        case (j)
            3'd0, 3'd1, 3'd2: d = OFS_NEG;
            3'd3, 3'd4:       d = OFS_ZERO;
            default:          d = OFS_POS;
        endcase
        return d;
    endfunction

    // cell (x,y) lives at y*GRID_MAX + x
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [SIDE_W-1:0] x,
                                                    input logic [SIDE_W-1:0] y);
        return {CELL_W'(y), CELL_W'(x)};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lgs_store.sv -----
// ----------------------------------------------------------------------------
// lgs_store
// One-bit cell memory, single port, registered read; cleared by a sweep
// of one entry per cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_store (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lgs_pkg::store_req_t req,
    output logic                    rdata,
    output logic                    clr_busy
);
    import lgs_pkg::*;

    logic              mem [DEPTH];
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= 1'b0;
        end
        else if (req.en && req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.en && !req.we)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata    = rdata_reg;
    assign clr_busy = clr_busy_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lattice_gas_swap_step_top.sv -----
// ----------------------------------------------------------------------------
// lattice_gas_swap_step_top
// Kawasaki exchange step on a square grid of one-bit cells held in memory.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* stream carries requests: s_tuser = req_type (load, read, swap).
//    One result transfer on m_* follows every request, in order.
//  - cfg_we/cfg_index/cfg_wdata write grid_side, accept_low, accept_high;
//    write only while the block is idle.
//  - An out-of-range or unused request goes straight to its result; a load
//    writes its cell, a read fetches its cell. A swap is bound by the
//    single memory port: 18 reads of center and neighbor cells, then up to
//    two write-backs. The next request is taken in the cycle after the
//    result is loaded into the output register.
//  - Reset clears the 4096-entry cell store, one entry per cycle; s_tready
//    stays low until the sweep ends. Config writes are taken throughout.
//  - If the receiver stalls, the finished result waits in the output
//    register; the block still takes one new request and works on it, then
//    holds until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_gas_swap_step_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [5:0] first_x, [11:6] first_y, [17:12] second_x, [23:18] second_y,
    // [24] load_value, [40:25] random_draw, [47:41] zero
    input  wire logic [47:0] s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] cell_value, [1] swapped, [5:2] energy_difference, [7:6] zero
    output logic [7:0]       m_tdata,
    // [0] status
    output logic             m_tuser,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata
);
    import lgs_pkg::*;

    `include "lattice_gas_swap_step_top_assert.svh"

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SCAN = 7'b0000010,
        ST_TAIL = 7'b0000100,
        ST_EVAL = 7'b0001000,
        ST_WRA  = 7'b0010000,
        ST_WRB  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    // configuration
    logic [SIDE_W-1:0] grid_side_reg;
    logic [CFG_W-1:0]  accept_low_reg;
    logic [CFG_W-1:0]  accept_high_reg;
    logic [SIDE_W-1:0] side;

    // sequencer
    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_last;

    // captured request
    req_t               req_reg;
    logic [SIDE_W-1:0]  ax_reg, ay_reg, bx_reg, by_reg;
    logic [DRAW_W-1:0]  draw_reg;
    logic               wval_a_reg, wval_b_reg;

    // read return tracking and accumulators
    logic              rd_pend_reg;
    logic [STEP_W-1:0] rd_step_reg;
    logic              rd_on_reg;
    logic              sa_reg, sb_reg;
    logic [CNT_W-1:0]  na_reg, nb_reg;

    // result under construction
    logic              res_status_reg, res_cell_reg, res_swapped_reg;
    logic [CNT_W-1:0]  res_ed_reg;

    // output register
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;
    logic              m_tuser_reg;
    logic              out_free;

    // store
    store_req_t        store_req;
    logic              store_rdata;
    logic              store_busy;

    // input decode
    req_t              in_req;
    logic [SIDE_W-1:0] in_ax, in_ay, in_bx, in_by;
    logic              in_bad;
    logic              accept;

    // scan address
    logic              scan_use_b, scan_nbr;
    logic [2:0]        scan_j;
    logic [SIDE_W-1:0] scan_x, scan_y;
    logic              scan_on;

    // evaluation
    logic [CNT_W-1:0]  diff;
    logic [DRAW_W-1:0] thr;
    logic              take_swap;

    lgs_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (store_req),
        .rdata    (store_rdata),
        .clr_busy (store_busy)
    );

    // a side beyond the store acts as the full store
    assign side = (grid_side_reg > SIDE_W'(SIDE_CAP)) ? SIDE_W'(SIDE_CAP) : grid_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg   <= SIDE_W'(64);
            accept_low_reg  <= '0;
            accept_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GRID_SIDE:   grid_side_reg   <= cfg_wdata[SIDE_W-1:0];
                CFG_ACCEPT_LOW:  accept_low_reg  <= cfg_wdata;
                CFG_ACCEPT_HIGH: accept_high_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------- input
    assign in_req = req_t'(s_tuser);
    assign in_ax  = SIDE_W'(s_tdata[5:0]);
    assign in_ay  = SIDE_W'(s_tdata[11:6]);
    assign in_bx  = SIDE_W'(s_tdata[17:12]);
    assign in_by  = SIDE_W'(s_tdata[23:18]);
    // load and read check the first cell only, a swap both
    assign in_bad = !(in_ax < side && in_ay < side) ||
                    (in_req == REQ_SWAP && !(in_bx < side && in_by < side));

    assign s_tready = (state_reg == ST_IDLE) && !store_busy;
    assign accept   = s_tvalid && s_tready;

    // --------------------------------------------------------- scan address
    assign step_last  = (req_reg == REQ_READ) ? '0 : STEP_W'(STEP_LAST_SWAP);
    assign scan_use_b = (step_reg == STEP_W'(STEP_B_CENTER)) ||
                        (step_reg >= STEP_W'(STEP_B_NBR));
    assign scan_nbr   = step_reg >= STEP_W'(STEP_A_NBR);
    assign scan_j     = scan_use_b ? 3'(step_reg - STEP_W'(STEP_B_NBR))
                                   : 3'(step_reg - STEP_W'(STEP_A_NBR));

    always_comb
    begin
        scan_x = scan_use_b ? bx_reg : ax_reg;
        scan_y = scan_use_b ? by_reg : ay_reg;
        if (scan_nbr)
        begin
            // x-1 at column 0 wraps to all ones, which is never below side
            scan_x = scan_x + nbr_dx(scan_j);
            scan_y = scan_y + nbr_dy(scan_j);
        end
    end

    assign scan_on = (scan_x < side) && (scan_y < side);

    always_comb
    begin
        store_req       = '0;
        store_req.en    = (state_reg == ST_SCAN) || (state_reg == ST_WRA) ||
                          (state_reg == ST_WRB);
        store_req.we    = (state_reg == ST_WRA) || (state_reg == ST_WRB);
        store_req.wdata = (state_reg == ST_WRA) ? wval_a_reg : wval_b_reg;
        case (state_reg)
            ST_SCAN: store_req.addr = cell_addr(scan_x, scan_y);
            ST_WRA:  store_req.addr = cell_addr(ax_reg, ay_reg);
            default: store_req.addr = cell_addr(bx_reg, by_reg);
        endcase
    end

    // ----------------------------------------------------------- evaluation
    assign diff = (na_reg > nb_reg) ? (na_reg - nb_reg) : (nb_reg - na_reg);

    always_comb
    begin
        case (diff)
            4'd0:    thr = THR_HALF;
            4'd1:    thr = accept_low_reg[15:0];
            4'd2:    thr = accept_low_reg[31:16];
            4'd3:    thr = accept_low_reg[47:32];
            4'd4:    thr = accept_low_reg[63:48];
            4'd5:    thr = accept_high_reg[15:0];
            4'd6:    thr = accept_high_reg[31:16];
            4'd7:    thr = accept_high_reg[47:32];
            4'd8:    thr = accept_high_reg[63:48];
            default: thr = '0;
        endcase
    end

    assign take_swap = (req_reg == REQ_SWAP) && (sa_reg != sb_reg) && (draw_reg < thr);
    assign out_free  = !m_tvalid_reg || m_tready;

    // --------------------------------------------------------- state machine
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_req == REQ_NONE || in_bad)
                        state_next = ST_DONE;
                    else if (in_req == REQ_LOAD)
                        state_next = ST_WRA;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN: if (step_reg == step_last) state_next = ST_TAIL;
            ST_TAIL: state_next = ST_EVAL;
            ST_EVAL: state_next = take_swap ? ST_WRA : ST_DONE;
            ST_WRA:  state_next = (req_reg == REQ_LOAD) ? ST_DONE : ST_WRB;
            ST_WRB:  state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_SCAN);
            if (state_reg == ST_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // datapath, set up at accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg         <= in_req;
            ax_reg          <= in_ax;
            ay_reg          <= in_ay;
            bx_reg          <= in_bx;
            by_reg          <= in_by;
            draw_reg        <= s_tdata[40:25];
            wval_a_reg      <= s_tdata[24];
            step_reg        <= '0;
            na_reg          <= '0;
            nb_reg          <= '0;
            res_status_reg  <= (in_req != REQ_NONE) && in_bad;
            res_cell_reg    <= 1'b0;
            res_swapped_reg <= 1'b0;
            res_ed_reg      <= '0;
        end

        if (state_reg == ST_SCAN)
        begin
            step_reg    <= step_reg + STEP_W'(1);
            rd_step_reg <= step_reg;
            rd_on_reg   <= scan_on;
        end

        // read data lands in the cycle after the address
        if (rd_pend_reg)
        begin
            if (rd_step_reg == '0)
                sa_reg <= store_rdata;
            else if (rd_step_reg == STEP_W'(STEP_B_CENTER))
                sb_reg <= store_rdata;
            else if (rd_step_reg < STEP_W'(STEP_B_NBR))
                na_reg <= na_reg + CNT_W'(store_rdata & rd_on_reg);
            else
                nb_reg <= nb_reg + CNT_W'(store_rdata & rd_on_reg);
        end

        if (state_reg == ST_EVAL)
        begin
            res_cell_reg <= (req_reg == REQ_READ) && sa_reg;
            if (req_reg == REQ_SWAP && sa_reg != sb_reg)
                res_ed_reg <= diff;
            if (take_swap)
            begin
                res_swapped_reg <= 1'b1;
                wval_a_reg      <= sb_reg;
                wval_b_reg      <= sa_reg;
            end
        end

        if (state_reg == ST_DONE && out_free)
        begin
            m_tdata_reg <= {2'b00, res_ed_reg, res_swapped_reg, res_cell_reg};
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------ assertions
    `LGS_ASSERT_IMPLY(a_no_accept_in_clear, store_busy, !s_tready,
                      "request taken while the cell store is clearing")
    `LGS_ASSERT_IMPLY(a_write_after_clear, store_req.en && store_req.we, !store_busy,
                      "cell write issued during the clearing sweep")
    `LGS_ASSERT_IMPLY(a_flagged_result_clean, m_tvalid_reg && m_tuser_reg,
                      m_tdata_reg == 8'h00, "out-of-range result carries data")
    `LGS_ASSERT_IMPLY(a_second_write_is_swap, state_reg == ST_WRB,
                      res_swapped_reg && req_reg == REQ_SWAP,
                      "second cell write without a taken swap")

endmodule

`default_nettype wire

// ----- dv/lattice_gas_swap_step_top_tb.sv -----
// ----------------------------------------------------------------------------
// lattice_gas_swap_step_top_tb
// Self-checking bench for the lattice gas swap step block. Load, read and
// swap requests stream in on s_*. A local copy of the cell grid and the
// registers predicts each result, and every m_* transfer is checked in order
// against it. The run covers directed corner cases first, then random phases
// with different grid sides, thresholds and back-pressure patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_gas_swap_step_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lgs_pkg::*;

    // one request as it travels on s_tdata / s_tuser
    typedef struct {
        req_t                kind;
        logic [COORD_W-1:0]  first_x;
        logic [COORD_W-1:0]  first_y;
        logic [COORD_W-1:0]  second_x;
        logic [COORD_W-1:0]  second_y;
        logic                load_value;
        logic [DRAW_W-1:0]   draw;
    } lattice_req_t;

    // one result as it travels on m_tdata / m_tuser
    typedef struct {
        logic              status;
        logic              cell_value;
        logic              swapped;
        logic [CNT_W-1:0]  delta_count;
    } lattice_res_t;

    localparam int DRAIN_CYCLES = 30;    // longer than the slowest swap
    localparam int HOLD_OFF     = 300;   // long receiver stall for back-pressure

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;

    lattice_gas_swap_step_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Predictor state: mirror of the cell grid and the registers
    // ------------------------------------------------------------------------
    bit                cell_state [DEPTH];          // cleared, as after reset
    logic [SIDE_W-1:0] side_cfg      = SIDE_W'(64);
    logic [63:0]       accept_lo_cfg = '0;
    logic [63:0]       accept_hi_cfg = '0;

    lattice_req_t request_q [$];    // requests not yet offered
    lattice_res_t outcome_q [$];    // predicted results, oldest first
    lattice_req_t offered;          // request currently on s_*
    lattice_res_t want;
    bit           offered_taken = 1'b0;

    int errors       = 0;
    int results_seen = 0;
    int hold_cycles  = 0;
    int idle_pct     = 0;           // sender idle chance per cycle
    int stall_pct    = 0;           // receiver stall chance per cycle

    // ------------------------------------------------------------------------
    // Grid helpers; cells off the active grid read as empty
    // ------------------------------------------------------------------------
    function automatic bit on_grid(input int x, input int y, input int side);
        return x >= 0 && y >= 0 && x < side && y < side;
    endfunction

    function automatic bit occupied(input int x, input int y, input int side);
        if (!on_grid(x, y, side))
            return 1'b0;
        return cell_state[y * GRID_MAX + x];
    endfunction

    function automatic int occupied_neighbors(input int x, input int y, input int side);
        int n = 0;
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
                if (dx != 0 || dy != 0)
                    n += occupied(x + dx, y + dy, side);
        return n;
    endfunction

    // Applies one request to the mirror grid and returns the result it yields.
    function automatic lattice_res_t predict_exchange(input lattice_req_t r);
        lattice_res_t      res;
        int                side, ax, ay, bx, by, na, nb, d;
        bit                sa, sb;
        logic [DRAW_W-1:0] thr;
        res  = '{default: '0};
        side = (side_cfg > GRID_MAX) ? GRID_MAX : int'(side_cfg);
        ax   = r.first_x;
        ay   = r.first_y;
        bx   = r.second_x;
        by   = r.second_y;
        if (r.kind == REQ_NONE)
            return res;
        // load/read look at the first cell only, a swap at both
        if (!on_grid(ax, ay, side) || (r.kind == REQ_SWAP && !on_grid(bx, by, side)))
        begin
            res.status = 1'b1;
            return res;
        end
        case (r.kind)
            REQ_LOAD: cell_state[ay * GRID_MAX + ax] = r.load_value;
            REQ_READ: res.cell_value = occupied(ax, ay, side);
            default:
            begin
                sa = occupied(ax, ay, side);
                sb = occupied(bx, by, side);
                // equal states (same cell included) leave everything alone
                if (sa != sb)
                begin
                    na = occupied_neighbors(ax, ay, side);
                    nb = occupied_neighbors(bx, by, side);
                    d  = (na > nb) ? na - nb : nb - na;
                    res.delta_count = CNT_W'(d);
                    if (d == 0)
                        thr = THR_HALF;
                    else if (d <= 4)
                        thr = accept_lo_cfg[16 * (d - 1) +: 16];
                    else
                        thr = accept_hi_cfg[16 * (d - 5) +: 16];
                    if (r.draw < thr)
                    begin
                        cell_state[ay * GRID_MAX + ax] = sb;
                        cell_state[by * GRID_MAX + bx] = sa;
                        res.swapped = 1'b1;
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [3:0] exp_val,
                                        input logic [3:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // register write at a falling edge; the mirror follows at once since
    // writes only happen with the block idle
    task automatic write_register(input cfg_idx_t idx, input logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_GRID_SIDE:  side_cfg = value[SIDE_W-1:0];
            CFG_ACCEPT_LOW: accept_lo_cfg = value;
            default:        accept_hi_cfg = value;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_request(input req_t kind, input int ax, input int ay,
                               input int bx, input int by, input logic lv,
                               input logic [DRAW_W-1:0] draw);
        lattice_req_t r;
        r.kind       = kind;
        r.first_x    = COORD_W'(ax);
        r.first_y    = COORD_W'(ay);
        r.second_x   = COORD_W'(bx);
        r.second_y   = COORD_W'(by);
        r.load_value = lv;
        r.draw       = draw;
        request_q.push_back(r);
    endtask

    // wait until every request is out and every result is back, then let
    // the pipeline settle before anything else touches the registers
    task automatic drain_requests();
        do
            @(posedge clk);
        while (request_q.size() != 0 || s_tvalid || outcome_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Request driver: falling edge; a new request goes out once the
    // previous transfer completed or the bus was idle
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!s_tvalid || offered_taken)
        begin
            offered_taken = 1'b0;
            if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                offered = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, offered.draw, offered.load_value,
                             offered.second_y, offered.second_x,
                             offered.first_y, offered.first_x};
                s_tuser  <= offered.kind;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // request transfer: predict right away, in acceptance order
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            outcome_q.push_back(predict_exchange(offered));
            offered_taken = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stalls, plus a counted hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // result monitor: compare each transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (outcome_q.size() == 0)
            begin
                $error("result transfer with nothing outstanding: status %0b, data %h",
                       m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                want = outcome_q.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("cell_value", want.cell_value, m_tdata[0]);
                check_field("swapped", want.swapped, m_tdata[1]);
                check_field("energy_difference", want.delta_count, m_tdata[5:2]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int           phase_sides [8] = '{64, 6, 127, 16, 1, 0, 0, 3};
        int           phase_items [8] = '{230, 230, 230, 230, 100, 230, 40, 150};
        int           se, pick, ax, ay, bx, by, mark;
        lattice_req_t r;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed: full grid, mixed thresholds --------------------------
        // d1 FFFF, d2 4000, d3 0000, d4 FFFF / d5 FFFF, d6 8000, d7 FFFF, d8 0001
        write_register(CFG_GRID_SIDE, 64'd64);
        write_register(CFG_ACCEPT_LOW, 64'hFFFF_0000_4000_FFFF);
        write_register(CFG_ACCEPT_HIGH, 64'h0001_FFFF_8000_FFFF);
        add_request(REQ_READ, 0, 0, 0, 0, 1'b0, 16'h0000);      // cleared store
        add_request(REQ_READ, 63, 63, 0, 0, 1'b0, 16'h0000);
        add_request(REQ_LOAD, 0, 0, 0, 0, 1'b1, 16'h0000);
        add_request(REQ_LOAD, 1, 0, 0, 0, 1'b1, 16'h0000);
        add_request(REQ_LOAD, 63, 63, 63, 63, 1'b1, 16'hFFFF);
        add_request(REQ_READ, 0, 0, 0, 0, 1'b0, 16'h0000);
        add_request(REQ_SWAP, 0, 0, 0, 0, 1'b0, 16'h0000);      // same cell twice
        add_request(REQ_SWAP, 0, 0, 63, 63, 1'b0, 16'h0000);    // equal states
        add_request(REQ_SWAP, 0, 0, 0, 1, 1'b0, 16'h0000);      // corner, taken
        add_request(REQ_SWAP, 63, 63, 62, 62, 1'b0, 16'hFFFF);  // draw at top
        // zero difference: fixed one-half threshold, just below and at it
        add_request(REQ_LOAD, 10, 10, 0, 0, 1'b1, 16'h0000);
        add_request(REQ_SWAP, 10, 10, 20, 20, 1'b0, 16'h7FFF);
        add_request(REQ_SWAP, 20, 20, 10, 10, 1'b0, 16'h8000);
        // difference of eight: fully surrounded empty cell vs lone particle
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
                if (dx != 0 || dy != 0)
                    add_request(REQ_LOAD, 30 + dx, 30 + dy, 0, 0, 1'b1, 16'h0000);
        add_request(REQ_SWAP, 30, 30, 20, 20, 1'b0, 16'h0000);
        add_request(REQ_NONE, 63, 63, 63, 63, 1'b1, 16'hFFFF); // unused type
        drain_requests();

        // --- directed: coordinates past a reduced side -----------------------
        write_register(CFG_GRID_SIDE, 64'd10);
        add_request(REQ_LOAD, 10, 3, 0, 0, 1'b1, 16'h0000);
        add_request(REQ_READ, 3, 10, 0, 0, 1'b0, 16'h0000);
        add_request(REQ_SWAP, 1, 1, 10, 0, 1'b0, 16'h0000);    // second cell off grid
        add_request(REQ_SWAP, 63, 0, 0, 0, 1'b0, 16'h0000);    // first cell off grid
        add_request(REQ_READ, 9, 9, 0, 0, 1'b0, 16'h0000);
        drain_requests();

        // --- directed: side zero, side above max, shrunk then regrown --------
        write_register(CFG_GRID_SIDE, 64'd0);
        add_request(REQ_READ, 0, 0, 0, 0, 1'b0, 16'h0000);
        add_request(REQ_LOAD, 0, 0, 0, 0, 1'b0, 16'h0000);
        drain_requests();
        write_register(CFG_GRID_SIDE, 64'd127);
        add_request(REQ_READ, 63, 63, 0, 0, 1'b0, 16'h0000);
        drain_requests();
        write_register(CFG_GRID_SIDE, 64'd2);
        add_request(REQ_READ, 63, 63, 0, 0, 1'b0, 16'h0000);
        drain_requests();
        write_register(CFG_GRID_SIDE, 64'd64);
        add_request(REQ_READ, 63, 63, 0, 0, 1'b0, 16'h0000);   // contents kept
        drain_requests();

        // --- random phases ----------------------------------------------------
        phase_sides[5] = $urandom_range(2, 63);
        for (int p = 0; p < 8; p++)
        begin
            write_register(CFG_GRID_SIDE, 64'(phase_sides[p]));
            case (p % 3)
                0:
                begin
                    write_register(CFG_ACCEPT_LOW, {$urandom, $urandom});
                    write_register(CFG_ACCEPT_HIGH, {$urandom, $urandom});
                end
                1:
                begin
                    write_register(CFG_ACCEPT_LOW, '1);
                    write_register(CFG_ACCEPT_HIGH, '1);
                end
                default:
                begin
                    write_register(CFG_ACCEPT_LOW, '0);
                    write_register(CFG_ACCEPT_HIGH, '1);
                end
            endcase
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 80; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase

            se = (phase_sides[p] > GRID_MAX) ? GRID_MAX : phase_sides[p];
            for (int k = 0; k < phase_items[p]; k++)
            begin
                // every field random first: this is the noise case
                r.kind       = req_t'($urandom_range(0, 3));
                r.first_x    = COORD_W'($urandom_range(0, 63));
                r.first_y    = COORD_W'($urandom_range(0, 63));
                r.second_x   = COORD_W'($urandom_range(0, 63));
                r.second_y   = COORD_W'($urandom_range(0, 63));
                r.load_value = 1'($urandom_range(0, 1));
                r.draw       = DRAW_W'($urandom_range(0, 65535));
                pick         = $urandom_range(0, 99);
                // mostly well-formed traffic on the active grid
                if (se > 0 && pick >= 8)
                begin
                    ax = $urandom_range(0, se - 1);
                    ay = $urandom_range(0, se - 1);
                    r.first_x = COORD_W'(ax);
                    r.first_y = COORD_W'(ay);
                    if (pick < 25)
                        r.kind = REQ_LOAD;
                    else if (pick < 33)
                        r.kind = REQ_READ;
                    else
                    begin
                        r.kind = REQ_SWAP;
                        if (pick < 75)
                        begin
                            // nearest-neighbor exchange, possibly the cell itself
                            bx = ax + int'($urandom_range(0, 2)) - 1;
                            by = ay + int'($urandom_range(0, 2)) - 1;
                            if (bx < 0 || bx >= se) bx = ax;
                            if (by < 0 || by >= se) by = ay;
                        end
                        else
                        begin
                            bx = $urandom_range(0, se - 1);
                            by = $urandom_range(0, se - 1);
                        end
                        r.second_x = COORD_W'(bx);
                        r.second_y = COORD_W'(by);
                    end
                end
                request_q.push_back(r);
            end

            // back-pressure: stop the receiver long enough to fill the block
            if (p == 0)
            begin
                mark = results_seen;
                while (results_seen < mark + 20) @(posedge clk);
                hold_cycles = HOLD_OFF;
            end
            drain_requests();
        end

        if (outcome_q.size() != 0)
        begin
            $error("%0d predicted results never arrived", outcome_q.size());
            errors++;
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog: far above the slowest legal run, reset clearing included
    initial
    begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
